// File: hw/rtl/sphe_pkg.sv
// shared constants, codes and control structs of the substring hash engine
package sphe_pkg;

   localparam int MAX_LEN_DEFAULT = 1024;

   localparam logic [60:0] HASH_P = 61'h1FFF_FFFF_FFFF_FFFF;
   localparam logic [60:0] HASH_BASE_RESET = 61'd768614336404564650;
   localparam logic [9:0]  HASH_OFFSET = 10'd997;

   localparam logic [2:0] OP_LOAD  = 3'd0;
   localparam logic [2:0] OP_BUILD = 3'd1;
   localparam logic [2:0] OP_FWD   = 3'd2;
   localparam logic [2:0] OP_REV   = 3'd3;
   localparam logic [2:0] OP_CLEAR = 3'd4;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_RANGE     = 2'd1;
   localparam logic [1:0] ST_NOT_BUILT = 2'd2;

   typedef enum logic [1:0] {
      MSEL_X_BASE   = 2'd0,
      MSEL_PW_BASE  = 2'd1,
      MSEL_PW_X     = 2'd2,
      MSEL_ACC_BASE = 2'd3
   } mul_sel_type;

   typedef struct packed {
      logic        latch_req;
      logic        set_check;
      logic        do_clear;
      logic        rd_phase_b;
      logic        cap_a;
      logic        mul_start;
      mul_sel_type mul_sel;
      logic        cap_t;
      logic        load_write;
      logic        cap_query;
      logic        build_init;
      logic        build_step;
      logic        out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic [2:0] op;
      logic [1:0] chk_status;
      logic       count_zero;
      logic       idx_last;
      logic       mul_done;
      logic       out_free;
   } dp_stat_type;

endpackage

// File: hw/rtl/sphe_req_if.sv
// request channel: operation and operands
interface sphe_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] op;
   logic [7:0] ch;
   logic [9:0] left_index;
   logic [9:0] right_index;

   modport source (output valid, op, ch, left_index, right_index, input ready);
   modport sink (input valid, op, ch, left_index, right_index, output ready);
endinterface

// File: hw/rtl/sphe_rsp_if.sv
// response channel: hash, status and string length
interface sphe_rsp_if;
   logic        valid;
   logic        ready;
   logic [60:0] hash_value;
   logic [1:0]  status;
   logic [10:0] string_length;

   modport source (output valid, hash_value, status, string_length, input ready);
   modport sink (input valid, hash_value, status, string_length, output ready);
endinterface

// File: hw/rtl/sphe_csr_if.sv
// configuration write channel: hash base
interface sphe_csr_if;
   logic        valid;
   logic        ready;
   logic [60:0] hash_base;

   modport source (output valid, hash_base, input ready);
   modport sink (input valid, hash_base, output ready);
endinterface

// File: hw/rtl/sphe_mulmod.sv
// multicycle multiply modulo 2^61-1 with one 32x32 multiplier
module sphe_mulmod (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [60:0] a,
   input  logic [60:0] b,
   output logic        done,
   output logic [60:0] result
);
   import sphe_pkg::*;

   localparam logic [2:0] STEP_FOLD1 = 3'd4;
   localparam logic [2:0] STEP_FOLD2 = 3'd5;

   logic        busy_ff, busy_in;
   logic [2:0]  step_ff, step_in;
   logic        done_ff, done_in;
   logic [60:0] a_ff, b_ff, res_ff;
   logic [121:0] acc_ff;
   logic [61:0] s_ff;
   logic [31:0] a_half, b_half;
   logic [63:0] pp;
   logic [121:0] pp_ext;
   logic [60:0] s2;

   assign a_half = step_ff[0] ? {3'b000, a_ff[60:32]} : a_ff[31:0];
   assign b_half = step_ff[1] ? {3'b000, b_ff[60:32]} : b_ff[31:0];
   assign pp = a_half * b_half;

   always_comb begin
      case ({1'b0, step_ff[0]} + {1'b0, step_ff[1]})
         2'd0: pp_ext = {58'd0, pp};
         2'd1: pp_ext = {26'd0, pp, 32'd0};
         default: pp_ext = {pp[57:0], 64'd0};
      endcase
   end

   // second fold leaves at most P+1, one subtract finishes it
   always_comb begin
      s2 = s_ff[60:0] + {60'd0, s_ff[61]};
      if (s2 >= HASH_P) begin
         s2 = s2 - HASH_P;
      end
   end

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      done_in = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         step_in = 3'd0;
      end else if (busy_ff) begin
         step_in = step_ff + 3'd1;
         if (step_ff == STEP_FOLD2) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= 3'd0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff <= a;
         b_ff <= b;
         acc_ff <= '0;
      end else if (busy_ff) begin
         if (step_ff < STEP_FOLD1) begin
            acc_ff <= acc_ff + pp_ext;
         end else if (step_ff == STEP_FOLD1) begin
            s_ff <= {1'b0, acc_ff[60:0]} + {1'b0, acc_ff[121:61]};
         end else begin
            res_ff <= s2;
         end
      end
   end

   assign done = done_ff;
   assign result = res_ff;
endmodule

// File: hw/rtl/sphe_datapath.sv
// tables, counters, operand registers, modular multiplier and output register
module sphe_datapath #(
   parameter int MAX_LEN = sphe_pkg::MAX_LEN_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  sphe_pkg::dp_cmd_type cmd,
   output sphe_pkg::dp_stat_type stat,
   input  logic [2:0]          req_op,
   input  logic [7:0]          req_ch,
   input  logic [9:0]          req_left_index,
   input  logic [9:0]          req_right_index,
   input  logic                csr_write,
   input  logic [60:0]         csr_hash_base,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic [60:0]         rsp_hash_value,
   output logic [1:0]          rsp_status,
   output logic [10:0]         rsp_string_length
);
   import sphe_pkg::*;

   localparam int CW = $clog2(MAX_LEN + 1);
   localparam int SW = $clog2(MAX_LEN + 2);
   localparam int BW = $clog2(MAX_LEN);
   localparam int XW = ((SW > 11) ? SW : 11) + 1;

   function automatic logic [60:0] add_byte(input logic [60:0] h, input logic [7:0] c);
      logic [61:0] v;
      v = {1'b0, h} + {54'd0, c} + {52'd0, HASH_OFFSET};
      if (v >= {1'b0, HASH_P}) begin
         v = v - {1'b0, HASH_P};
      end
      return v[60:0];
   endfunction

   logic [7:0]  byte_mem [MAX_LEN];
   logic [60:0] pre_mem [MAX_LEN + 1];
   logic [60:0] pow_mem [MAX_LEN + 1];
   logic [60:0] suf_mem [MAX_LEN + 2];

   logic [2:0]  op_ff;
   logic [7:0]  ch_ff;
   logic [9:0]  left_ff, right_ff;
   logic [60:0] base_ff;
   logic [CW-1:0] count_ff;
   logic        built_ff;
   logic [CW-1:0] idx_ff;
   logic [60:0] acc_ff, x_ff, pw_ff, t_ff;
   logic [7:0]  byte_rd_ff;
   logic [60:0] pre_rd_ff, pow_rd_ff, suf_rd_ff;
   logic        pre_zero_ff, pow_zero_ff;
   logic        out_valid_ff;
   logic [60:0] out_hash_ff, res_hash_ff;
   logic [1:0]  out_status_ff, res_status_ff;
   logic [10:0] out_len_ff;

   logic [XW-1:0] l_x, r_x, cnt_x;
   logic [CW-1:0] pre_addr, pow_addr;
   logic [SW-1:0] suf_addr, suf_waddr;
   logic [60:0] suf_wdata, pre_val, pow_val, x_val, y_val;
   logic [60:0] mul_a, mul_b, mul_res, new_acc;
   logic        mul_done, range_err, out_free;
   logic [1:0]  chk;

   assign l_x = XW'(left_ff);
   assign r_x = XW'(right_ff);
   assign cnt_x = XW'(count_ff);
   assign range_err = (l_x > r_x) || (r_x >= cnt_x);

   always_comb begin
      case (op_ff)
         OP_LOAD: chk = (count_ff == CW'(MAX_LEN)) ? ST_RANGE : ST_OK;
         OP_FWD:  chk = range_err ? ST_RANGE : ST_OK;
         OP_REV:  chk = !built_ff ? ST_NOT_BUILT : (range_err ? ST_RANGE : ST_OK);
         default: chk = ST_OK;
      endcase
   end

   // phase a reads the multiplied operand, phase b the subtracted one
   always_comb begin
      if (op_ff == OP_LOAD) begin
         pre_addr = count_ff;
         pow_addr = count_ff;
      end else begin
         pre_addr = cmd.rd_phase_b ? CW'(r_x + XW'(1)) : CW'(l_x);
         pow_addr = CW'(r_x - l_x + XW'(1));
      end
      suf_addr = cmd.rd_phase_b ? SW'(l_x + XW'(1)) : SW'(r_x + XW'(2));
   end

   // entry zero of the prefix and power tables is never written
   assign pre_val = pre_zero_ff ? 61'd0 : pre_rd_ff;
   assign pow_val = pow_zero_ff ? 61'd1 : pow_rd_ff;
   assign x_val = (op_ff == OP_REV) ? suf_rd_ff : pre_val;
   assign y_val = x_val;

   always_comb begin
      case (cmd.mul_sel)
         MSEL_X_BASE:  begin mul_a = x_ff;   mul_b = base_ff; end
         MSEL_PW_BASE: begin mul_a = pw_ff;  mul_b = base_ff; end
         MSEL_PW_X:    begin mul_a = pw_ff;  mul_b = x_ff;    end
         default:      begin mul_a = acc_ff; mul_b = base_ff; end
      endcase
   end

   sphe_mulmod u_mulmod (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.mul_start),
      .a      (mul_a),
      .b      (mul_b),
      .done   (mul_done),
      .result (mul_res)
   );

   assign new_acc = add_byte(mul_res, byte_rd_ff);
   assign suf_waddr = cmd.build_init ? SW'(cnt_x + XW'(1)) : SW'(idx_ff);
   assign suf_wdata = cmd.build_init ? 61'd0 : new_acc;

   always_ff @(posedge clock) begin
      if (cmd.load_write) begin
         byte_mem[BW'(count_ff)] <= ch_ff;
         pre_mem[count_ff + CW'(1)] <= t_ff;
         pow_mem[count_ff + CW'(1)] <= mul_res;
      end
      if (cmd.build_init || cmd.build_step) begin
         suf_mem[suf_waddr] <= suf_wdata;
      end
      byte_rd_ff <= byte_mem[BW'(idx_ff - CW'(1))];
      pre_rd_ff <= pre_mem[pre_addr];
      pow_rd_ff <= pow_mem[pow_addr];
      suf_rd_ff <= suf_mem[suf_addr];
      pre_zero_ff <= (pre_addr == '0);
      pow_zero_ff <= (pow_addr == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= HASH_BASE_RESET;
         count_ff <= '0;
         built_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            base_ff <= csr_hash_base;
         end
         if (cmd.do_clear) begin
            count_ff <= '0;
            built_ff <= 1'b0;
         end else if (cmd.load_write) begin
            count_ff <= count_ff + CW'(1);
            built_ff <= 1'b0;
         end else if (cmd.build_init) begin
            built_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         op_ff <= req_op;
         ch_ff <= req_ch;
         left_ff <= req_left_index;
         right_ff <= req_right_index;
      end
      if (cmd.set_check) begin
         res_status_ff <= chk;
         res_hash_ff <= 61'd0;
      end
      if (cmd.cap_a) begin
         x_ff <= x_val;
         pw_ff <= pow_val;
      end
      if (cmd.cap_t) begin
         t_ff <= add_byte(mul_res, ch_ff);
      end
      if (cmd.cap_query) begin
         res_hash_ff <= (y_val >= mul_res) ? (y_val - mul_res) : (y_val + HASH_P - mul_res);
      end
      if (cmd.build_init) begin
         acc_ff <= 61'd0;
         idx_ff <= count_ff;
      end else if (cmd.build_step) begin
         acc_ff <= new_acc;
         idx_ff <= idx_ff - CW'(1);
      end
      if (cmd.out_load) begin
         out_hash_ff <= res_hash_ff;
         out_status_ff <= res_status_ff;
         out_len_ff <= 11'(count_ff);
      end
   end

   assign out_free = !out_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign stat.op = op_ff;
   assign stat.chk_status = chk;
   assign stat.count_zero = (count_ff == '0);
   assign stat.idx_last = (idx_ff == CW'(1));
   assign stat.mul_done = mul_done;
   assign stat.out_free = out_free;

   assign rsp_valid = out_valid_ff;
   assign rsp_hash_value = out_hash_ff;
   assign rsp_status = out_status_ff;
   assign rsp_string_length = out_len_ff;
endmodule

// File: hw/rtl/sphe_ctrl.sv
// controller state machine sequencing loads, builds, queries and clears
module sphe_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  sphe_pkg::dp_stat_type stat,
   output sphe_pkg::dp_cmd_type  cmd
);
   import sphe_pkg::*;

   typedef enum logic [11:0] {
      S_IDLE       = 12'b0000_0000_0001,
      S_DECODE     = 12'b0000_0000_0010,
      S_RD_A       = 12'b0000_0000_0100,
      S_RD_B       = 12'b0000_0000_1000,
      S_MUL1_GO    = 12'b0000_0001_0000,
      S_MUL1_WAIT  = 12'b0000_0010_0000,
      S_MUL2_GO    = 12'b0000_0100_0000,
      S_MUL2_WAIT  = 12'b0000_1000_0000,
      S_BUILD_INIT = 12'b0001_0000_0000,
      S_BUILD_GO   = 12'b0010_0000_0000,
      S_BUILD_WAIT = 12'b0100_0000_0000,
      S_FINISH     = 12'b1000_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      is_load;

   assign is_load = (stat.op == OP_LOAD);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      cmd.mul_sel = is_load ? MSEL_X_BASE : MSEL_PW_X;
      cmd.rd_phase_b = (state_ff != S_RD_A);
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.set_check = 1'b1;
            case (stat.op)
               OP_LOAD, OP_FWD, OP_REV: begin
                  state_in = (stat.chk_status == ST_OK) ? S_RD_A : S_FINISH;
               end
               OP_BUILD: state_in = S_BUILD_INIT;
               OP_CLEAR: begin
                  cmd.do_clear = 1'b1;
                  state_in = S_FINISH;
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_RD_A: state_in = S_RD_B;
         S_RD_B: begin
            cmd.cap_a = 1'b1;
            state_in = S_MUL1_GO;
         end
         S_MUL1_GO: begin
            cmd.mul_start = 1'b1;
            state_in = S_MUL1_WAIT;
         end
         S_MUL1_WAIT: begin
            if (stat.mul_done) begin
               if (is_load) begin
                  cmd.cap_t = 1'b1;
                  state_in = S_MUL2_GO;
               end else begin
                  cmd.cap_query = 1'b1;
                  state_in = S_FINISH;
               end
            end
         end
         S_MUL2_GO: begin
            cmd.mul_sel = MSEL_PW_BASE;
            cmd.mul_start = 1'b1;
            state_in = S_MUL2_WAIT;
         end
         S_MUL2_WAIT: begin
            cmd.mul_sel = MSEL_PW_BASE;
            if (stat.mul_done) begin
               cmd.load_write = 1'b1;
               state_in = S_FINISH;
            end
         end
         S_BUILD_INIT: begin
            cmd.build_init = 1'b1;
            state_in = stat.count_zero ? S_FINISH : S_BUILD_GO;
         end
         S_BUILD_GO: begin
            cmd.mul_sel = MSEL_ACC_BASE;
            cmd.mul_start = 1'b1;
            state_in = S_BUILD_WAIT;
         end
         S_BUILD_WAIT: begin
            cmd.mul_sel = MSEL_ACC_BASE;
            if (stat.mul_done) begin
               cmd.build_step = 1'b1;
               state_in = stat.idx_last ? S_FINISH : S_BUILD_GO;
            end
         end
         S_FINISH: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

// File: hw/rtl/substring_polynomial_hash_engine_core.sv
// top level of the substring polynomial hash engine modulo 2^61-1
//
//   channel   dir  handshake     payload
//   req_ch    in   valid/ready   op, ch, left_index, right_index
//   rsp_ch    out  valid/ready   hash_value, status, string_length
//   csr_ch    in   valid/ready   hash_base (always ready)
//
// one transaction at a time; each product is a start state plus a wait state until the multiplier is done
// a query takes one product, a load two, a build one per stored byte
// errors and clear skip the multiplier; unused opcodes give no response
// synchronous reset clears control state; tables need no clearing pass
// a stalled response sits in the output register while the next request is taken
module substring_polynomial_hash_engine_core #(
   parameter int MAX_LEN = sphe_pkg::MAX_LEN_DEFAULT
) (
   input logic         clock,
   input logic         reset,
   sphe_req_if.sink    req_ch,
   sphe_rsp_if.source  rsp_ch,
   sphe_csr_if.sink    csr_ch
);
   import sphe_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   assign csr_ch.ready = 1'b1;

   sphe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   sphe_datapath #(
      .MAX_LEN (MAX_LEN)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_op            (req_ch.op),
      .req_ch            (req_ch.ch),
      .req_left_index    (req_ch.left_index),
      .req_right_index   (req_ch.right_index),
      .csr_write         (csr_ch.valid),
      .csr_hash_base     (csr_ch.hash_base),
      .rsp_ready         (rsp_ch.ready),
      .rsp_valid         (rsp_ch.valid),
      .rsp_hash_value    (rsp_ch.hash_value),
      .rsp_status        (rsp_ch.status),
      .rsp_string_length (rsp_ch.string_length)
   );
endmodule
